>>> rtl/link_reconnect_backoff_fsm_macros.svh
// Assertion macros shared by the link reconnect backoff controller RTL.
`ifndef LINK_RECONNECT_BACKOFF_FSM_MACROS_SVH
`define LINK_RECONNECT_BACKOFF_FSM_MACROS_SVH

`ifndef ASSERT_OFF

// Overlapping implication, checked outside reset.
`define LRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// Next-cycle implication, checked outside reset.
`define LRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define LRB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LRB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/lrb_pkg.sv
// Types and constants for the link reconnect backoff controller.
package lrb_pkg;

   localparam int unsigned TIME_BITS_DEFAULT  = 32;
   localparam int unsigned COUNT_BITS_DEFAULT = 16;

   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CREDENTIALS     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_BACKOFF = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONNECT_TIMEOUT = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_BACKOFF     = 2'd3;

   localparam logic [CSR_DATA_BITS-1:0] INITIAL_BACKOFF_RESET = 32'd1000;
   localparam logic [CSR_DATA_BITS-1:0] CONNECT_TIMEOUT_RESET = 32'd10000;
   localparam logic [CSR_DATA_BITS-1:0] MAX_BACKOFF_RESET     = 32'd60000;

   localparam int unsigned     FAIL_FIELD_BITS = 16;
   localparam logic [15:0]     FAIL_FIELD_MAX  = 16'hFFFF;

   typedef enum logic [1:0] {
      LINK_DISCONNECTED = 2'd0,
      LINK_CONNECTING   = 2'd1,
      LINK_CONNECTED    = 2'd2
   } lrb_mode_type;

   typedef struct packed {
      logic [15:0] delta_ms;
      logic        link_up;
   } lrb_req_type;

   typedef struct packed {
      logic                       state_changed;
      logic                       start_connect;
      logic [1:0]                 link_state;
      logic                       is_connected;
      logic [FAIL_FIELD_BITS-1:0] failure_count;
   } lrb_rsp_type;

   typedef struct packed {
      logic                     credentials_present;
      logic [CSR_DATA_BITS-1:0] initial_backoff_ms;
      logic [CSR_DATA_BITS-1:0] connect_timeout_ms;
      logic [CSR_DATA_BITS-1:0] max_backoff_ms;
   } lrb_cfg_type;

endpackage

>>> rtl/link_reconnect_backoff_fsm.sv
// Top level of the link reconnect controller with exponential backoff.
// A tick is held in the input stage; the core's result is registered when it advances.
// Throughput: one tick per cycle unless rsp_ready stalls; the input stage and result
// register move together. While a result waits, the input stage holds one more tick.
// Reset (synchronous, active high) restores register defaults, disconnected
// mode, zero counters and the initial backoff; no clearing pass follows.
`include "link_reconnect_backoff_fsm_macros.svh"

module link_reconnect_backoff_fsm
   import lrb_pkg::*;
#(
   parameter int unsigned TIME_BITS  = TIME_BITS_DEFAULT,
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  lrb_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output lrb_rsp_type               rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   lrb_cfg_type cfg_ff;
   logic        s1_valid_ff;
   lrb_req_type s1_data_ff;
   logic        rsp_valid_ff;
   lrb_rsp_type rsp_data_ff;
   lrb_rsp_type core_rsp;
   logic        s1_adv;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.credentials_present <= 1'b0;
         cfg_ff.initial_backoff_ms  <= INITIAL_BACKOFF_RESET;
         cfg_ff.connect_timeout_ms  <= CONNECT_TIMEOUT_RESET;
         cfg_ff.max_backoff_ms      <= MAX_BACKOFF_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CREDENTIALS:     cfg_ff.credentials_present <= csr_wdata[0];
            CSR_INITIAL_BACKOFF: cfg_ff.initial_backoff_ms  <= csr_wdata;
            CSR_CONNECT_TIMEOUT: cfg_ff.connect_timeout_ms  <= csr_wdata;
            CSR_MAX_BACKOFF:     cfg_ff.max_backoff_ms      <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: hold until the next transaction moves in
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= core_rsp;
      end
   end

   lrb_core #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (s1_adv),
      .req   (s1_data_ff),
      .cfg   (cfg_ff),
      .rsp   (core_rsp)
   );

   `LRB_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff && $stable(s1_data_ff))
   `LRB_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, s1_adv, rsp_valid_ff)
   `LRB_ASSERT_IMPL(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !s1_adv)

endmodule

>>> rtl/lrb_core.sv
// Link controller state, time-in-state counter, backoff and failure count.
`include "link_reconnect_backoff_fsm_macros.svh"

module lrb_core
   import lrb_pkg::*;
#(
   parameter int unsigned TIME_BITS  = TIME_BITS_DEFAULT,
   parameter int unsigned COUNT_BITS = COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  lrb_req_type req,
   input  lrb_cfg_type cfg,
   output lrb_rsp_type rsp
);

   localparam int unsigned CMP_BITS = (TIME_BITS > CSR_DATA_BITS) ? TIME_BITS : CSR_DATA_BITS;
   localparam int unsigned FC_BITS  = (COUNT_BITS > FAIL_FIELD_BITS) ? COUNT_BITS
                                                                     : FAIL_FIELD_BITS;

   lrb_mode_type          mode_ff, mode_in;
   logic [TIME_BITS-1:0]  time_ff, time_in;
   logic [TIME_BITS-1:0]  backoff_ff, backoff_in;
   logic [COUNT_BITS-1:0] failures_ff, failures_in;

   logic [TIME_BITS:0]    time_sum;
   logic [TIME_BITS-1:0]  time_add;
   logic [TIME_BITS-1:0]  backoff_dbl;
   logic [TIME_BITS-1:0]  backoff_next;
   logic                  timeout_hit;
   logic                  wait_done;
   logic                  changed;
   logic                  start;
   logic [FC_BITS-1:0]    fc_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= LINK_DISCONNECTED;
         time_ff     <= '0;
         backoff_ff  <= TIME_BITS'(INITIAL_BACKOFF_RESET);
         failures_ff <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         time_ff     <= time_in;
         backoff_ff  <= backoff_in;
         failures_ff <= failures_in;
      end
   end

   always_comb begin
      // saturating time-in-state update
      time_sum = {1'b0, time_ff} + (TIME_BITS + 1)'(req.delta_ms);
      time_add = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];

      timeout_hit = CMP_BITS'(time_add) >= CMP_BITS'(cfg.connect_timeout_ms);
      wait_done   = CMP_BITS'(time_add) >= CMP_BITS'(backoff_ff);

      // double with saturation, then clamp to the configured maximum
      backoff_dbl  = backoff_ff[TIME_BITS-1] ? '1 : {backoff_ff[TIME_BITS-2:0], 1'b0};
      backoff_next = (CMP_BITS'(backoff_dbl) > CMP_BITS'(cfg.max_backoff_ms))
                     ? TIME_BITS'(cfg.max_backoff_ms) : backoff_dbl;

      mode_in     = mode_ff;
      time_in     = time_ff;
      backoff_in  = backoff_ff;
      failures_in = failures_ff;
      changed     = 1'b0;
      start       = 1'b0;

      if (cfg.credentials_present) begin
         time_in = time_add;
         case (mode_ff)
            LINK_CONNECTING: begin
               if (req.link_up) begin
                  failures_in = '0;
                  backoff_in  = TIME_BITS'(cfg.initial_backoff_ms);
                  mode_in     = LINK_CONNECTED;
                  changed     = 1'b1;
               end else if (timeout_hit) begin
                  if (failures_ff != '1) begin
                     failures_in = failures_ff + COUNT_BITS'(1);
                  end
                  backoff_in = backoff_next;
                  mode_in    = LINK_DISCONNECTED;
                  changed    = 1'b1;
               end
            end
            LINK_CONNECTED: begin
               if (!req.link_up) begin
                  mode_in = LINK_DISCONNECTED;
                  changed = 1'b1;
               end
            end
            default: begin
               // unused code folds into disconnected
               mode_in = LINK_DISCONNECTED;
               if (wait_done) begin
                  mode_in = LINK_CONNECTING;
                  start   = 1'b1;
                  changed = 1'b1;
               end
            end
         endcase
         if (changed) begin
            time_in = '0;
         end
      end

      fc_wide = FC_BITS'(failures_in);

      rsp.state_changed = changed;
      rsp.start_connect = start;
      rsp.link_state    = mode_in;
      rsp.is_connected  = (mode_in == LINK_CONNECTED);
      rsp.failure_count = (fc_wide > FC_BITS'(FAIL_FIELD_MAX)) ? FAIL_FIELD_MAX
                                                               : fc_wide[FAIL_FIELD_BITS-1:0];
   end

   `LRB_ASSERT_NEXT(a_start_enters_connecting, clock, reset, step && rsp.start_connect, mode_ff == LINK_CONNECTING)
   `LRB_ASSERT_NEXT(a_change_clears_time, clock, reset, step && rsp.state_changed, time_ff == '0)
   `LRB_ASSERT_NEXT(a_idle_holds_failures, clock, reset, step && !cfg.credentials_present, $stable(failures_ff) && $stable(time_ff))
   `LRB_ASSERT_IMPL(a_start_only_from_disc, clock, reset, step && rsp.start_connect, mode_ff != LINK_CONNECTING && mode_ff != LINK_CONNECTED)

endmodule

>>> test/link_reconnect_backoff_fsm_test.sv
// Self-checking testbench for the link reconnect controller with exponential backoff.
module link_reconnect_backoff_fsm_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lrb_pkg::*;

   // Tracks the controller state per accepted tick and holds the outcomes still due.
   class backoff_tracker;
      bit                 credentials;
      bit [31:0]          initial_backoff;
      bit [31:0]          connect_timeout;
      bit [31:0]          max_backoff;
      lrb_mode_type       mode;
      bit [31:0]          time_in_mode;
      bit [31:0]          backoff_wait;
      bit [15:0]          failures;
      lrb_rsp_type        expected_outcomes[$];
      int unsigned        mismatches;

      function new();
         credentials     = 1'b0;
         initial_backoff = INITIAL_BACKOFF_RESET;
         connect_timeout = CONNECT_TIMEOUT_RESET;
         max_backoff     = MAX_BACKOFF_RESET;
         mode            = LINK_DISCONNECTED;
         time_in_mode    = '0;
         backoff_wait    = INITIAL_BACKOFF_RESET;
         failures        = '0;
         mismatches      = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] value);
         case (index)
            CSR_CREDENTIALS:     credentials     = value[0];
            CSR_INITIAL_BACKOFF: initial_backoff = value;
            CSR_CONNECT_TIMEOUT: connect_timeout = value;
            CSR_MAX_BACKOFF:     max_backoff     = value;
            default: ;
         endcase
      endfunction

      function void note_tick(lrb_req_type tick);
         bit           changed;
         bit           start;
         bit [32:0]    sum;
         lrb_mode_type next_mode;
         lrb_rsp_type  outcome;
         changed = 1'b0;
         start   = 1'b0;
         if (credentials) begin
            sum = {1'b0, time_in_mode} + 33'(tick.delta_ms);
            time_in_mode = sum[32] ? '1 : sum[31:0];
            next_mode = mode;
            case (mode)
               LINK_CONNECTING: begin
                  if (tick.link_up) begin
                     failures     = '0;
                     backoff_wait = initial_backoff;
                     next_mode    = LINK_CONNECTED;
                  end else if (time_in_mode >= connect_timeout) begin
                     if (failures != '1) failures++;
                     // saturate the doubling, then clamp
                     backoff_wait = backoff_wait[31] ? '1 : {backoff_wait[30:0], 1'b0};
                     if (backoff_wait > max_backoff) backoff_wait = max_backoff;
                     next_mode = LINK_DISCONNECTED;
                  end
               end
               LINK_CONNECTED: begin
                  if (!tick.link_up) next_mode = LINK_DISCONNECTED;
               end
               default: begin
                  next_mode = LINK_DISCONNECTED;
                  if (time_in_mode >= backoff_wait) begin
                     start     = 1'b1;
                     next_mode = LINK_CONNECTING;
                  end
               end
            endcase
            if (next_mode != mode) begin
               changed      = 1'b1;
               mode         = next_mode;
               time_in_mode = '0;
            end
         end
         outcome.state_changed = changed;
         outcome.start_connect = start;
         outcome.link_state    = mode;
         outcome.is_connected  = (mode == LINK_CONNECTED);
         outcome.failure_count = failures;
         expected_outcomes.push_back(outcome);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_outcome(lrb_rsp_type got);
         lrb_rsp_type want;
         if (expected_outcomes.size() == 0) begin
            $error("outcome transaction with none expected");
            mismatches++;
            return;
         end
         want = expected_outcomes.pop_front();
         compare_field("state_changed", 32'(want.state_changed), 32'(got.state_changed));
         compare_field("start_connect", 32'(want.start_connect), 32'(got.start_connect));
         compare_field("link_state", 32'(want.link_state), 32'(got.link_state));
         compare_field("is_connected", 32'(want.is_connected), 32'(got.is_connected));
         compare_field("failure_count", 32'(want.failure_count), 32'(got.failure_count));
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   lrb_req_type               req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   lrb_rsp_type               rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int unsigned    sender_idle_pct = 0;
   int unsigned    receiver_idle_pct = 0;
   backoff_tracker tracker = new();

   link_reconnect_backoff_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_outcome(rsp_data);
   end

   task automatic send_tick(input logic [15:0] delta, input logic up);
      lrb_req_type tick;
      tick.delta_ms = delta;
      tick.link_up  = up;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      do @(posedge clock); while (!req_ready);
      tracker.note_tick(tick);
   endtask

   // Hold until every outcome is back, then let the pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.expected_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(index, value);
   endtask

   task automatic configure(input logic [31:0] creds, input logic [31:0] init_ms,
                            input logic [31:0] timeout_ms, input logic [31:0] max_ms);
      write_reg(CSR_CREDENTIALS, creds);
      write_reg(CSR_INITIAL_BACKOFF, init_ms);
      write_reg(CSR_CONNECT_TIMEOUT, timeout_ms);
      write_reg(CSR_MAX_BACKOFF, max_ms);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] random_time_ms();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(1, 100);
         3, 4:    return $urandom_range(100, 5000);
         5, 6:    return $urandom_range(1000, 70000);
         7:       return $urandom_range(50000, 300000);
         8:       return $urandom;
         default: return 32'd1000;
      endcase
   endfunction

   function automatic logic [15:0] random_delta(input int unsigned cap);
      case ($urandom_range(19))
         0:       return '0;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, cap));
      endcase
   endfunction

   initial begin
      int unsigned delta_cap;
      int unsigned success_pct;
      logic        up;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // parked without credentials
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'd0, 1'b0);
      wait_drained();
      write_reg(CSR_CREDENTIALS, 32'd1);
      csr_we <= 1'b0;

      // default timing: exact backoff, exact timeout, doubled wait, success, link loss
      send_tick(16'd999, 1'b0);
      send_tick(16'd1, 1'b0);
      send_tick(16'd9999, 1'b0);
      send_tick(16'd1, 1'b0);
      send_tick(16'd1999, 1'b1);
      send_tick(16'd1, 1'b0);
      send_tick(16'd0, 1'b1);
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'd0, 1'b0);

      // upper bits of the credentials write are dropped, so this parks the block
      wait_drained();
      configure(32'hFFFF_FFFE, 32'd0, 32'd0, 32'd0);
      send_tick(16'd100, 1'b1);

      // zero timing: the loaded backoff survives a rewrite of the initial value
      wait_drained();
      configure(32'd1, 32'd0, 32'd0, 32'd0);
      send_tick(16'd1000, 1'b0);
      send_tick(16'd0, 1'b0);
      send_tick(16'd0, 1'b0);
      send_tick(16'd0, 1'b1);
      send_tick(16'd0, 1'b0);
      send_tick(16'd0, 1'b0);

      for (int phase = 0; phase < 13; phase++) begin
         if (phase < 5) begin
            sender_idle_pct   = 16;
            receiver_idle_pct = 45;
         end else if (phase < 9) begin
            sender_idle_pct   = 45;
            receiver_idle_pct = 16;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         wait_drained();
         configure(($urandom & 32'hFFFF_FFFE) | ($urandom_range(7) != 0),
                   random_time_ms(), random_time_ms(), random_time_ms());
         case ($urandom_range(3))
            0:       delta_cap = 15;
            1:       delta_cap = 255;
            2:       delta_cap = 4095;
            default: delta_cap = 65535;
         endcase
         success_pct = $urandom_range(10, 60);
         repeat (150) begin
            case (tracker.mode)
               LINK_CONNECTING: up = ($urandom_range(99) < success_pct);
               LINK_CONNECTED:  up = ($urandom_range(99) < 92);
               default:         up = 1'($urandom_range(1));
            endcase
            send_tick(random_delta(delta_cap), up);
         end
      end

      wait_drained();
      if (tracker.mismatches == 0 && tracker.expected_outcomes.size() == 0) begin
         $display("** link_reconnect_backoff_fsm: PASSED **");
      end else begin
         $display("** link_reconnect_backoff_fsm: FAILED **");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("** link_reconnect_backoff_fsm: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/lrb_pkg.sv
rtl/lrb_core.sv
rtl/link_reconnect_backoff_fsm.sv
test/link_reconnect_backoff_fsm_test.sv
